// ===== src/yuv_pair_to_rgb565_defines.svh =====
// ----------------------------------------------------------------------------
// YUV pair to RGB565 assertion macros
// Shared property wrappers for the checker of the pixel pair converter.
// ----------------------------------------------------------------------------
`ifndef YUV_PAIR_TO_RGB565_DEFINES_SVH
`define YUV_PAIR_TO_RGB565_DEFINES_SVH

// Assertion sampled on the rising clock edge and switched off during reset.
`define Y2RGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define Y2RGB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/y2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// YUV pair to RGB565 package
// Fixed-point BT.601 coefficients, channel saturation and pixel packing.
// ----------------------------------------------------------------------------
package y2rgb_pkg;

  typedef logic [7:0]         sample_t;
  typedef logic signed [7:0]  chroma_t;
  typedef logic [18:0]        luma_scaled_t;
  typedef logic signed [19:0] term_t;
  typedef logic signed [20:0] chan_sum_t;
  typedef logic [17:0]        chan_t;
  typedef logic [15:0]        pixel_t;

  localparam sample_t            LUMA_OFFSET = 8'd16;
  localparam logic [10:0]        K_LUMA      = 11'd1192;
  localparam logic signed [12:0] K_RED_CR    = 13'sd1634;
  localparam logic signed [12:0] K_GREEN_CR  = 13'sd833;
  localparam logic signed [12:0] K_GREEN_CB  = 13'sd400;
  localparam logic signed [12:0] K_BLUE_CB   = 13'sd2066;
  localparam chan_sum_t          CHAN_MAX    = 21'sd262143;

  function automatic chan_t sat_chan(input chan_sum_t x);
    chan_t res;
    if (x < 0) begin
      res = '0;
    end else if (x > CHAN_MAX) begin
      res = '1;
    end else begin
      res = x[17:0];
    end
    return res;
  endfunction

  function automatic pixel_t pack_pixel(input chan_t r, input chan_t g, input chan_t b);
    return {r[17:13], g[17:12], b[17:13]};
  endfunction

endpackage

// ===== src/yuv_pair_to_rgb565.sv =====
// ----------------------------------------------------------------------------
// YUV pair to RGB565 converter
// Converts two luma samples sharing one Cb/Cr pair into two RGB565 pixels
// using BT.601 limited-range coefficients in 10-bit fixed point.
// ----------------------------------------------------------------------------
//  Channel   Ports                                           Handshake
//  request   luma_first luma_second chroma_blue chroma_red   start, busy
//  result    pixel_first pixel_second                        done
//
// A request enters in every cycle; busy is always low.
// The result appears after the last stage, one cycle wide on done.
// The four stages are offset removal, coefficient multiply, green chroma sum,
// and channel sum with saturation and packing.
// Synchronous reset clears the stage valid bits and so drops requests in flight.
module yuv_pair_to_rgb565 (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  y2rgb_pkg::sample_t  luma_first,
  input  y2rgb_pkg::sample_t  luma_second,
  input  y2rgb_pkg::sample_t  chroma_blue,
  input  y2rgb_pkg::sample_t  chroma_red,
  output logic                done,
  output y2rgb_pkg::pixel_t   pixel_first,
  output y2rgb_pkg::pixel_t   pixel_second
);
  import y2rgb_pkg::*;

  logic         valid1;
  logic         valid2;
  logic         valid3;
  sample_t      y1_off;
  sample_t      y2_off;
  chroma_t      cb1;
  chroma_t      cr1;
  luma_scaled_t ys1_2;
  luma_scaled_t ys2_2;
  term_t        red_add2;
  term_t        green_cr2;
  term_t        green_cb2;
  term_t        blue_add2;
  luma_scaled_t ys1_3;
  luma_scaled_t ys2_3;
  term_t        red_add3;
  term_t        green_sub3;
  term_t        blue_add3;
  chan_sum_t    r1_sum;
  chan_sum_t    g1_sum;
  chan_sum_t    b1_sum;
  chan_sum_t    r2_sum;
  chan_sum_t    g2_sum;
  chan_sum_t    b2_sum;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= start && !busy;
      valid2 <= valid1;
      valid3 <= valid2;
      done   <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    y1_off <= (luma_first > LUMA_OFFSET) ? luma_first - LUMA_OFFSET : '0;
    y2_off <= (luma_second > LUMA_OFFSET) ? luma_second - LUMA_OFFSET : '0;
    cb1    <= chroma_t'({~chroma_blue[7], chroma_blue[6:0]});
    cr1    <= chroma_t'({~chroma_red[7], chroma_red[6:0]});
  end

  always_ff @(posedge clk) begin
    ys1_2     <= 19'(y1_off) * 19'(K_LUMA);
    ys2_2     <= 19'(y2_off) * 19'(K_LUMA);
    red_add2  <= 20'(cr1) * 20'(K_RED_CR);
    green_cr2 <= 20'(cr1) * 20'(K_GREEN_CR);
    green_cb2 <= 20'(cb1) * 20'(K_GREEN_CB);
    blue_add2 <= 20'(cb1) * 20'(K_BLUE_CB);
  end

  always_ff @(posedge clk) begin
    ys1_3      <= ys1_2;
    ys2_3      <= ys2_2;
    red_add3   <= red_add2;
    green_sub3 <= green_cr2 + green_cb2;
    blue_add3  <= blue_add2;
  end

  always_comb begin
    r1_sum = $signed({2'b00, ys1_3}) + 21'(red_add3);
    g1_sum = $signed({2'b00, ys1_3}) - 21'(green_sub3);
    b1_sum = $signed({2'b00, ys1_3}) + 21'(blue_add3);
    r2_sum = $signed({2'b00, ys2_3}) + 21'(red_add3);
    g2_sum = $signed({2'b00, ys2_3}) - 21'(green_sub3);
    b2_sum = $signed({2'b00, ys2_3}) + 21'(blue_add3);
  end

  always_ff @(posedge clk) begin
    pixel_first  <= pack_pixel(sat_chan(r1_sum), sat_chan(g1_sum), sat_chan(b1_sum));
    pixel_second <= pack_pixel(sat_chan(r2_sum), sat_chan(g2_sum), sat_chan(b2_sum));
  end

endmodule

// ===== src/yuv_pair_to_rgb565_checker.sv =====
// ----------------------------------------------------------------------------
// YUV pair to RGB565 checker
// Port-level checks on request acceptance, result timing and known colors.
// ----------------------------------------------------------------------------
`include "yuv_pair_to_rgb565_defines.svh"

module yuv_pair_to_rgb565_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [7:0]  luma_first,
  input logic [7:0]  luma_second,
  input logic [7:0]  chroma_blue,
  input logic [7:0]  chroma_red,
  input logic        done,
  input logic [15:0] pixel_first,
  input logic [15:0] pixel_second
);

  logic [3:0] rst_hist;
  logic       settled;
  logic       accepted;
  logic       black_req;
  logic       white_req;

  always_ff @(posedge clk) begin
    rst_hist <= {rst_hist[2:0], rst};
  end

  assign settled   = (rst_hist == 4'b0000);
  assign accepted  = start && !busy;
  assign black_req = accepted && (luma_first <= 8'd16) &&
                     (chroma_blue == 8'd128) && (chroma_red == 8'd128);
  assign white_req = accepted && (luma_second == 8'd255) &&
                     (chroma_blue == 8'd128) && (chroma_red == 8'd128);

  `Y2RGB_ASSERT_ALWAYS(never_busy, !busy, "busy was raised")
  `Y2RGB_ASSERT(done_latency, settled |-> (done == $past(accepted, 4)), "done off by latency")
  `Y2RGB_ASSERT(black_pixel, (settled && done && $past(black_req, 4)) |-> (pixel_first == 16'h0000), "black nonzero")
  `Y2RGB_ASSERT(white_pixel, (settled && done && $past(white_req, 4)) |-> (pixel_second == 16'hFFFF), "white low")

endmodule

bind yuv_pair_to_rgb565 yuv_pair_to_rgb565_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .luma_first   (luma_first),
  .luma_second  (luma_second),
  .chroma_blue  (chroma_blue),
  .chroma_red   (chroma_red),
  .done         (done),
  .pixel_first  (pixel_first),
  .pixel_second (pixel_second)
);

// ===== tb/yuv_pair_to_rgb565_tb.sv =====
// ----------------------------------------------------------------------------
// YUV pair to RGB565 converter testbench
// Sends luma pairs with shared chroma, directed corner cases first and then
// random pairs with random gaps, predicts both RGB565 pixels of every accepted
// request and compares each result on done in order against the prediction.
// ----------------------------------------------------------------------------
module yuv_pair_to_rgb565_tb;
  import y2rgb_pkg::*;

  localparam int RANDOM_PAIRS = 650;
  localparam int IDLE_LIMIT   = 400;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    pixel_t first;
    pixel_t second;
  } pixel_pair_t;

  class pixel_pair_board;
    pixel_pair_t pixels_q[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [17:0] clamp_channel(input int sum);
      if (sum < 0) begin
        return 18'd0;
      end else if (sum > 262143) begin
        return 18'h3ffff;
      end
      return sum[17:0];
    endfunction

    function pixel_t convert_pixel(input sample_t luma, input sample_t cb, input sample_t cr);
      int          y_term;
      int          cb_ofs;
      int          cr_ofs;
      logic [17:0] red;
      logic [17:0] green;
      logic [17:0] blue;
      y_term = (luma < 8'd16) ? 0 : (int'(luma) - 16) * 1192;
      cb_ofs = int'(cb) - 128;
      cr_ofs = int'(cr) - 128;
      red    = clamp_channel(y_term + 1634 * cr_ofs);
      green  = clamp_channel(y_term - (833 * cr_ofs + 400 * cb_ofs));
      blue   = clamp_channel(y_term + 2066 * cb_ofs);
      return {red[17:13], green[17:12], blue[17:13]};
    endfunction

    function void note_request(input sample_t y1, input sample_t y2,
                               input sample_t cb, input sample_t cr);
      pixel_pair_t pair;
      pair.first  = convert_pixel(y1, cb, cr);
      pair.second = convert_pixel(y2, cb, cr);
      pixels_q = {pixels_q, pair};
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      $display("tb: mismatch at %0t: %s", $realtime, what);
    endtask

    task check_pixels(input pixel_t got_first, input pixel_t got_second);
      pixel_pair_t want;
      if (pixels_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h %h", got_first, got_second));
        return;
      end
      want = pixels_q.pop_front();
      if (got_first !== want.first) begin
        report_mismatch($sformatf("pixel_first %h, expected %h", got_first, want.first));
      end
      if (got_second !== want.second) begin
        report_mismatch($sformatf("pixel_second %h, expected %h", got_second, want.second));
      end
    endtask
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  sample_t luma_first;
  sample_t luma_second;
  sample_t chroma_blue;
  sample_t chroma_red;
  logic    done;
  pixel_t  pixel_first;
  pixel_t  pixel_second;

  pixel_pair_board pair_board;
  int              idle_cycles;
  int              burst_left;

  yuv_pair_to_rgb565 dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .luma_first   (luma_first),
    .luma_second  (luma_second),
    .chroma_blue  (chroma_blue),
    .chroma_red   (chroma_red),
    .done         (done),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_pair(input sample_t y1, input sample_t y2,
                           input sample_t cb, input sample_t cr, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start       <= 1'b1;
    luma_first  <= y1;
    luma_second <= y2;
    chroma_blue <= cb;
    chroma_red  <= cr;
    @(posedge clk);
    while (busy) @(posedge clk);
    pair_board.note_request(y1, y2, cb, cr);
  endtask

  function automatic sample_t pick_sample();
    sample_t edges [12] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127,
                            8'd128, 8'd129, 8'd235, 8'd240, 8'd254, 8'd255};
    case ($urandom_range(0, 3))
      0: begin
        return edges[$urandom_range(0, 11)];
      end
      1: begin
        return sample_t'($urandom_range(16, 240));
      end
      default: begin
        return sample_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int gap;
    if (burst_left == 0 && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(10, 40);
    end
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
    end
    return gap;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      pair_board.check_pixels(pixel_first, pixel_second);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    pair_board  = new();
    burst_left  = 0;
    rst         = 1'b1;
    start       = 1'b0;
    luma_first  = '0;
    luma_second = '0;
    chroma_blue = '0;
    chroma_red  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corner cases: black floor, neutral chroma, and every channel clipping both ways.
    send_pair(8'd0,   8'd0,   8'd128, 8'd128, 0);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, 0);
    send_pair(8'd0,   8'd255, 8'd0,   8'd0,   0);
    send_pair(8'd15,  8'd16,  8'd128, 8'd128, 2);
    send_pair(8'd17,  8'd235, 8'd128, 8'd128, 0);
    send_pair(8'd235, 8'd16,  8'd128, 8'd255, 0);
    send_pair(8'd16,  8'd235, 8'd128, 8'd0,   5);
    send_pair(8'd16,  8'd255, 8'd255, 8'd128, 0);
    send_pair(8'd255, 8'd16,  8'd0,   8'd128, 1);
    send_pair(8'd16,  8'd128, 8'd255, 8'd255, 0);
    send_pair(8'd235, 8'd128, 8'd0,   8'd0,   0);
    send_pair(8'd240, 8'd1,   8'd16,  8'd240, 3);
    send_pair(8'd128, 8'd127, 8'd240, 8'd16,  0);
    send_pair(8'd81,  8'd145, 8'd90,  8'd240, 0);
    send_pair(8'd41,  8'd210, 8'd54,  8'd34,  19);
    send_pair(8'd170, 8'd85,  8'd170, 8'd85,  0);
    send_pair(8'd85,  8'd170, 8'd85,  8'd170, 0);
    send_pair(8'd254, 8'd1,   8'd129, 8'd127, 4);
    send_pair(8'd255, 8'd0,   8'd255, 8'd0,   0);
    send_pair(8'd0,   8'd255, 8'd0,   8'd255, 0);

    repeat (RANDOM_PAIRS) begin
      send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), pick_gap());
    end
    @(negedge clk);
    start <= 1'b0;

    while (pair_board.pixels_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pair_board.mismatches == 0 && pair_board.pixels_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
